/* sv/jrde_pkg.sv */
// Package for the joystick radial dead zone event block.
// Holds the sequencer state type, Q2.14 constants and the field codes.
// No dependencies.
package jrde_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [14:0] ONE_Q14    = 15'd16384;
    localparam logic [13:0] DZ_MAX     = 14'd8192;
    localparam logic [14:0] EDGE_LIMIT = 15'd15564;
    localparam logic [13:0] DZ_RESET   = 14'd819;
    localparam logic [14:0] THR_RESET  = 15'd164;

    localparam logic        CFG_DZ_RADIUS = 1'b0;
    localparam logic        CFG_MOVE_THR  = 1'b1;

    localparam logic        REQ_SAMPLE = 1'b0;
    localparam logic        REQ_POLL   = 1'b1;

    localparam logic [1:0]  EVT_MOVED   = 2'd0;
    localparam logic [1:0]  EVT_CENTRED = 2'd1;
    localparam logic [1:0]  EVT_EDGE    = 2'd2;

    localparam logic [3:0]  DIR_CENTRE     = 4'd0;
    localparam logic [3:0]  DIR_RIGHT      = 4'd1;
    localparam logic [3:0]  DIR_UP_RIGHT   = 4'd2;
    localparam logic [3:0]  DIR_UP         = 4'd3;
    localparam logic [3:0]  DIR_UP_LEFT    = 4'd4;
    localparam logic [3:0]  DIR_LEFT       = 4'd5;
    localparam logic [3:0]  DIR_DOWN_LEFT  = 4'd6;
    localparam logic [3:0]  DIR_DOWN       = 4'd7;
    localparam logic [3:0]  DIR_DOWN_RIGHT = 4'd8;

    localparam int ENTRY_W = 16 + 16 + 17 + 17 + 2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_DZ2,
        ST_CMP,
        ST_SQRT,
        ST_DEN,
        ST_MULN,
        ST_LDDIV,
        ST_DIV,
        ST_DELTA,
        ST_DX2,
        ST_DY2,
        ST_TH2,
        ST_SS,
        ST_AA,
        ST_DD,
        ST_EVT,
        ST_PUSH,
        ST_PRD,
        ST_PGET,
        ST_RESP
    } t_state;

endpackage

/* sv/jrde_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module jrde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/joystick_radial_deadzone_events.sv */
// Top level of the joystick radial dead zone event block.
// Uses jrde_pkg and jrde_ram (event queue).
//
// Usage:
//  Input channel (i_in_valid / o_in_stall) takes one request per beat: a stick
//  sample (raw_x, raw_y) or a poll that pops one queued event.
//  Output channel (o_out_valid / i_out_stall) gives one result per request.
//  Config channel (i_cfg_valid / o_cfg_ready) writes the dead zone radius
//  (index 0, clamped to 8192) and move_threshold (index 1); write only when idle.
//  A sample runs through one shared 18x18 multiplier, a 1-bit-per-cycle
//  square root and a 1-bit-per-cycle divider (one pass per axis); the root
//  and divider are skipped inside the dead zone, and queued events are pushed
//  one at a time.
//  One request at a time: o_in_stall is high from acceptance until the
//  result beat has been taken; the next beat can be taken in the cycle after that.
//  While i_out_stall is high the result holds.
//  Reset clears the queue pointers, the last position and the registers to
//  their defaults; the event store is not cleared and needs no sweep.
module joystick_radial_deadzone_events #(
    parameter int QUEUE_DEPTH = jrde_pkg::QUEUE_DEPTH_DEF,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [15:0]        i_raw_x,
    input  logic [15:0]        i_raw_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_resp_kind,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [16:0] o_move_dx,
    output logic signed [16:0] o_move_dy,
    output logic [3:0]         o_direction,
    output logic               o_is_centered,
    output logic               o_is_at_edge,
    output logic               o_event_valid,
    output logic [1:0]         o_event_kind,
    output logic [CW-1:0]      o_queue_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [14:0]        i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int EW = jrde_pkg::ENTRY_W;

    jrde_pkg::t_state r_state, n_state;

    logic [13:0]        r_dz;
    logic [14:0]        r_thr;
    logic signed [15:0] r_last_x, r_last_y;
    logic [AW-1:0]      r_head, r_tail;
    logic [CW-1:0]      r_count;

    logic signed [15:0] r_cx, r_cy, r_x, r_y;
    logic signed [16:0] r_dx, r_dy;
    logic signed [35:0] r_prod;
    logic [35:0]        r_acc, r_ss, r_aa;
    logic [29:0]        r_m2sh;
    logic [17:0]        r_srem;
    logic [14:0]        r_root;
    logic [28:0]        r_den, r_drem;
    logic [15:0]        r_qsh, r_q;
    logic [3:0]         r_cnt;
    logic               r_axis, r_moved;
    logic [2:0]         r_evt;

    logic               r_o_kind, r_o_cen, r_o_edge, r_o_ev;
    logic signed [15:0] r_o_px, r_o_py;
    logic signed [16:0] r_o_dx, r_o_dy;
    logic [3:0]         r_o_dir;
    logic [1:0]         r_o_ek;

    logic signed [17:0] mul_a, mul_b;
    logic               ram_we;
    logic [EW-1:0]      ram_wdata, ram_rdata;

    logic               in_acc;
    logic [14:0]        ax, ay, lax, lay, abs_c;
    logic [15:0]        sum_s;
    logic signed [15:0] diff_d;
    logic [17:0]        sq_sh, sq_trial;
    logic               sq_ge;
    logic [29:0]        dv_t;
    logic               dv_ge;
    logic [15:0]        q_fin, q_cl;
    logic signed [15:0] res;
    logic               is_c, was_c, is_e, was_e;
    logic [3:0]         dir;
    logic [1:0]         push_kind;
    logic               full;

    function automatic logic [14:0] abs16(input logic signed [15:0] v);
        logic [15:0] t;
        t = v[15] ? 16'(-v) : 16'(v);
        return t[14:0];
    endfunction

    assign in_acc = i_in_valid && !o_in_stall;
    assign full   = (r_count == CW'(QUEUE_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jrde_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == jrde_pkg::REQ_POLL) begin
                        n_state = (r_count == '0) ? jrde_pkg::ST_RESP : jrde_pkg::ST_PRD;
                    end else begin
                        n_state = jrde_pkg::ST_SQX;
                    end
                end
            end
            jrde_pkg::ST_SQX:   n_state = jrde_pkg::ST_SQY;
            jrde_pkg::ST_SQY:   n_state = jrde_pkg::ST_DZ2;
            jrde_pkg::ST_DZ2:   n_state = jrde_pkg::ST_CMP;
            jrde_pkg::ST_CMP: begin
                n_state = (r_acc >= 36'(r_prod)) ? jrde_pkg::ST_SQRT : jrde_pkg::ST_DELTA;
            end
            jrde_pkg::ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = jrde_pkg::ST_DEN;
                end
            end
            jrde_pkg::ST_DEN: begin
                n_state = (r_root == '0) ? jrde_pkg::ST_DELTA : jrde_pkg::ST_MULN;
            end
            jrde_pkg::ST_MULN:  n_state = jrde_pkg::ST_LDDIV;
            jrde_pkg::ST_LDDIV: n_state = jrde_pkg::ST_DIV;
            jrde_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_axis ? jrde_pkg::ST_DELTA : jrde_pkg::ST_MULN;
                end
            end
            jrde_pkg::ST_DELTA: n_state = jrde_pkg::ST_DX2;
            jrde_pkg::ST_DX2:   n_state = jrde_pkg::ST_DY2;
            jrde_pkg::ST_DY2:   n_state = jrde_pkg::ST_TH2;
            jrde_pkg::ST_TH2:   n_state = jrde_pkg::ST_SS;
            jrde_pkg::ST_SS:    n_state = jrde_pkg::ST_AA;
            jrde_pkg::ST_AA:    n_state = jrde_pkg::ST_DD;
            jrde_pkg::ST_DD:    n_state = jrde_pkg::ST_EVT;
            jrde_pkg::ST_EVT:   n_state = jrde_pkg::ST_PUSH;
            jrde_pkg::ST_PUSH: begin
                if (r_evt == '0) begin
                    n_state = jrde_pkg::ST_RESP;
                end
            end
            jrde_pkg::ST_PRD:   n_state = jrde_pkg::ST_PGET;
            jrde_pkg::ST_PGET:  n_state = jrde_pkg::ST_RESP;
            jrde_pkg::ST_RESP: begin
                if (!i_out_stall) begin
                    n_state = jrde_pkg::ST_IDLE;
                end
            end
            default:            n_state = jrde_pkg::ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_in_stall  = (r_state != jrde_pkg::ST_IDLE);
        o_out_valid = (r_state == jrde_pkg::ST_RESP);
        o_cfg_ready = (r_state == jrde_pkg::ST_IDLE);
        ram_we      = (r_state == jrde_pkg::ST_PUSH) && (r_evt != '0);
        mul_a       = '0;
        mul_b       = '0;
        case (r_state)
            jrde_pkg::ST_SQX: begin
                mul_a = 18'(r_cx);
                mul_b = 18'(r_cx);
            end
            jrde_pkg::ST_SQY: begin
                mul_a = 18'(r_cy);
                mul_b = 18'(r_cy);
            end
            jrde_pkg::ST_DZ2: begin
                mul_a = {4'b0, r_dz};
                mul_b = {4'b0, r_dz};
            end
            jrde_pkg::ST_DEN: begin
                mul_a = {3'b0, r_root};
                mul_b = {3'b0, jrde_pkg::ONE_Q14 - {1'b0, r_dz}};
            end
            jrde_pkg::ST_MULN: begin
                mul_a = {3'b0, abs_c};
                mul_b = {3'b0, r_root - {1'b0, r_dz}};
            end
            jrde_pkg::ST_DX2: begin
                mul_a = 18'(r_dx);
                mul_b = 18'(r_dx);
            end
            jrde_pkg::ST_DY2: begin
                mul_a = 18'(r_dy);
                mul_b = 18'(r_dy);
            end
            jrde_pkg::ST_TH2: begin
                mul_a = {3'b0, r_thr};
                mul_b = {3'b0, r_thr};
            end
            jrde_pkg::ST_SS: begin
                mul_a = {2'b0, sum_s};
                mul_b = {2'b0, sum_s};
            end
            jrde_pkg::ST_AA: begin
                mul_a = {3'b0, ax};
                mul_b = {3'b0, ax};
            end
            jrde_pkg::ST_DD: begin
                mul_a = 18'(diff_d);
                mul_b = 18'(diff_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign abs_c  = r_axis ? abs16(r_cy) : abs16(r_cx);
    assign ax     = abs16(r_x);
    assign ay     = abs16(r_y);
    assign lax    = abs16(r_last_x);
    assign lay    = abs16(r_last_y);
    assign sum_s  = {1'b0, ax} + {1'b0, ay};
    assign diff_d = signed'({1'b0, ay}) - signed'({1'b0, ax});

    assign sq_sh    = {r_srem[15:0], r_m2sh[29:28]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign dv_t  = {r_drem, r_qsh[15]};
    assign dv_ge = (dv_t >= {1'b0, r_den});
    assign q_fin = {r_q[14:0], dv_ge};
    assign q_cl  = (q_fin > 16'(jrde_pkg::ONE_Q14)) ? 16'(jrde_pkg::ONE_Q14) : q_fin;
    assign res   = (r_axis ? r_cy[15] : r_cx[15]) ? -signed'(q_cl) : signed'(q_cl);

    assign is_c  = (ax < {1'b0, r_dz}) && (ay < {1'b0, r_dz});
    assign was_c = (lax < {1'b0, r_dz}) && (lay < {1'b0, r_dz});
    assign is_e  = (ax > jrde_pkg::EDGE_LIMIT) || (ay > jrde_pkg::EDGE_LIMIT);
    assign was_e = (lax > jrde_pkg::EDGE_LIMIT) || (lay > jrde_pkg::EDGE_LIMIT);

    always_comb begin
        if (is_c) begin
            dir = jrde_pkg::DIR_CENTRE;
        end else if (ax == '0 && ay == '0) begin
            dir = jrde_pkg::DIR_RIGHT;
        end else if (r_ss < {r_aa[34:0], 1'b0}) begin
            dir = (r_x > 0) ? jrde_pkg::DIR_RIGHT : jrde_pkg::DIR_LEFT;
        end else if (diff_d > 0 && 36'(r_prod) > {r_aa[34:0], 1'b0}) begin
            dir = (r_y > 0) ? jrde_pkg::DIR_UP : jrde_pkg::DIR_DOWN;
        end else if (r_y > 0) begin
            dir = (r_x > 0) ? jrde_pkg::DIR_UP_RIGHT : jrde_pkg::DIR_UP_LEFT;
        end else begin
            dir = (r_x < 0) ? jrde_pkg::DIR_DOWN_LEFT : jrde_pkg::DIR_DOWN_RIGHT;
        end
    end

    assign push_kind = r_evt[0] ? jrde_pkg::EVT_MOVED :
                       r_evt[1] ? jrde_pkg::EVT_CENTRED : jrde_pkg::EVT_EDGE;
    assign ram_wdata = {r_x, r_y, r_dx, r_dy, push_kind};

    jrde_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= jrde_pkg::ST_IDLE;
            r_dz     <= jrde_pkg::DZ_RESET;
            r_thr    <= jrde_pkg::THR_RESET;
            r_last_x <= '0;
            r_last_y <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    jrde_pkg::CFG_DZ_RADIUS: begin
                        r_dz <= (i_cfg_data[13:0] > jrde_pkg::DZ_MAX) ?
                                jrde_pkg::DZ_MAX : i_cfg_data[13:0];
                    end
                    jrde_pkg::CFG_MOVE_THR:  r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == jrde_pkg::ST_EVT) begin
                r_last_x <= r_x;
                r_last_y <= r_y;
            end
            if (ram_we) begin
                r_tail <= (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                if (full) begin
                    r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (r_state == jrde_pkg::ST_PGET) begin
                r_head  <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            jrde_pkg::ST_IDLE: begin
                r_cx     <= signed'({1'b0, i_raw_x[15:1]}) - 16'sd16384;
                r_cy     <= signed'({1'b0, i_raw_y[15:1]}) - 16'sd16384;
                r_x      <= '0;
                r_y      <= '0;
                r_o_kind <= jrde_pkg::REQ_POLL;
                r_o_px   <= '0;
                r_o_py   <= '0;
                r_o_dx   <= '0;
                r_o_dy   <= '0;
                r_o_dir  <= jrde_pkg::DIR_CENTRE;
                r_o_cen  <= 1'b0;
                r_o_edge <= 1'b0;
                r_o_ev   <= 1'b0;
                r_o_ek   <= jrde_pkg::EVT_MOVED;
            end
            jrde_pkg::ST_SQY: r_acc <= 36'(r_prod);
            jrde_pkg::ST_DZ2: r_acc <= r_acc + 36'(r_prod);
            jrde_pkg::ST_CMP: begin
                r_m2sh <= r_acc[29:0];
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= 4'd14;
                r_axis <= 1'b0;
            end
            jrde_pkg::ST_SQRT: begin
                r_srem <= sq_ge ? sq_sh - sq_trial : sq_sh;
                r_root <= {r_root[13:0], sq_ge};
                r_m2sh <= {r_m2sh[27:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
            end
            jrde_pkg::ST_MULN: begin
                if (!r_axis) begin
                    r_den <= r_prod[28:0];
                end
            end
            jrde_pkg::ST_LDDIV: begin
                r_drem <= {2'b00, r_prod[28:2]};
                r_qsh  <= {r_prod[1:0], 14'b0};
                r_q    <= '0;
                r_cnt  <= 4'd15;
            end
            jrde_pkg::ST_DIV: begin
                r_drem <= dv_ge ? 29'(dv_t - {1'b0, r_den}) : dv_t[28:0];
                r_qsh  <= {r_qsh[14:0], 1'b0};
                r_q    <= q_fin;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_axis) begin
                        r_y <= res;
                    end else begin
                        r_x <= res;
                    end
                    r_axis <= 1'b1;
                end
            end
            jrde_pkg::ST_DELTA: begin
                r_dx <= 17'(r_x) - 17'(r_last_x);
                r_dy <= 17'(r_y) - 17'(r_last_y);
            end
            jrde_pkg::ST_DY2: r_acc   <= 36'(r_prod);
            jrde_pkg::ST_TH2: r_acc   <= r_acc + 36'(r_prod);
            jrde_pkg::ST_SS:  r_moved <= r_acc > 36'(r_prod);
            jrde_pkg::ST_AA:  r_ss    <= 36'(r_prod);
            jrde_pkg::ST_DD:  r_aa    <= 36'(r_prod);
            jrde_pkg::ST_EVT: begin
                r_evt    <= {!was_e && is_e, !was_c && is_c, r_moved};
                r_o_kind <= jrde_pkg::REQ_SAMPLE;
                r_o_px   <= r_x;
                r_o_py   <= r_y;
                r_o_dx   <= r_dx;
                r_o_dy   <= r_dy;
                r_o_dir  <= dir;
                r_o_cen  <= is_c;
                r_o_edge <= is_e;
            end
            jrde_pkg::ST_PUSH: begin
                if (r_evt[0]) begin
                    r_evt[0] <= 1'b0;
                end else if (r_evt[1]) begin
                    r_evt[1] <= 1'b0;
                end else begin
                    r_evt[2] <= 1'b0;
                end
            end
            jrde_pkg::ST_PGET: begin
                {r_o_px, r_o_py, r_o_dx, r_o_dy, r_o_ek} <= ram_rdata;
                r_o_ev <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_resp_kind   = r_o_kind;
    assign o_pos_x       = r_o_px;
    assign o_pos_y       = r_o_py;
    assign o_move_dx     = r_o_dx;
    assign o_move_dy     = r_o_dy;
    assign o_direction   = r_o_dir;
    assign o_is_centered = r_o_cen;
    assign o_is_at_edge  = r_o_edge;
    assign o_event_valid = r_o_ev;
    assign o_event_kind  = r_o_ek;
    assign o_queue_level = r_count;

endmodule

/* sv/jrde_checker.sv */
// Port-level checks for the joystick radial dead zone event block.
// Uses the top level's ports only; bound to joystick_radial_deadzone_events.
module jrde_checker #(
    parameter int QUEUE_DEPTH = jrde_pkg::QUEUE_DEPTH_DEF,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_req_type,
    input logic [15:0]        i_raw_x,
    input logic [15:0]        i_raw_y,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_resp_kind,
    input logic signed [15:0] o_pos_x,
    input logic signed [15:0] o_pos_y,
    input logic signed [16:0] o_move_dx,
    input logic signed [16:0] o_move_dy,
    input logic [3:0]         o_direction,
    input logic               o_is_centered,
    input logic               o_is_at_edge,
    input logic               o_event_valid,
    input logic [1:0]         o_event_kind,
    input logic [CW-1:0]      o_queue_level,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               i_cfg_index,
    input logic [14:0]        i_cfg_data
);

    // one beat in flight: no result while ready for a new beat
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid) else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall) else $error("not busy after beat");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_queue_level <= CW'(QUEUE_DEPTH)) else $error("queue level overflow");

    a_sample_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_resp_kind) |-> (!o_event_valid && o_event_kind == 2'd0))
        else $error("event fields on sample result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pos_x)
            && $stable(o_move_dx) && $stable(o_queue_level)))
        else $error("stalled result changed");

endmodule

bind joystick_radial_deadzone_events jrde_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CW          (CW)
) u_jrde_checker (.*);

/* tb/tb.sv */
// Self-checking bench for joystick_radial_deadzone_events: dead zone, rescale,
// direction sectors and the drop-oldest event queue, predicted in-bench.
// Depends on jrde_pkg and the block itself.
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [3:0]         dir;
        logic               cen;
        logic               edge_f;
        logic               ev_valid;
        logic [1:0]         ev_kind;
        logic [4:0]         level;
    } t_stick_res;

    typedef struct packed {
        logic        req;
        logic [15:0] rx;
        logic [15:0] ry;
        logic        has_exp;
        t_stick_res  exp_res;
    } t_stick_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_req_type = jrde_pkg::REQ_SAMPLE;
    logic [15:0] i_raw_x = 16'd0;
    logic [15:0] i_raw_y = 16'd0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_resp_kind;
    logic signed [15:0] o_pos_x, o_pos_y;
    logic signed [16:0] o_move_dx, o_move_dy;
    logic [3:0] o_direction;
    logic o_is_centered, o_is_at_edge, o_event_valid;
    logic [1:0] o_event_kind;
    logic [4:0] o_queue_level;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = jrde_pkg::CFG_DZ_RADIUS;
    logic [14:0] i_cfg_data = 15'd0;

    always #5 i_clk = ~i_clk;

    joystick_radial_deadzone_events u_dut (.*);

    // predictor state
    longint dz_q = 819, thr_q = 164;
    longint last_x, last_y;
    t_stick_res evq[$];
    t_stick_res want_q[$];
    t_stick_res pinned_q[$];
    bit pinned_v[$];
    int errors = 0;
    int send_idle = 0, recv_stall = 0;

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint isqrt(longint v);
        longint r = 0;
        while ((r + 1) * (r + 1) <= v) r = r + 1;
        return r;
    endfunction

    function automatic longint stretch(longint c, longint mag, longint dz);
        longint q;
        q = (iabs(c) * (mag - dz) * 16384) / (mag * (16384 - dz));
        if (q > 16384) q = 16384;
        return c < 0 ? -q : q;
    endfunction

    function automatic logic [3:0] sector(longint x, longint y);
        longint ax, ay, s, d;
        ax = iabs(x); ay = iabs(y); s = ax + ay; d = ay - ax;
        if (ax == 0 && ay == 0) return jrde_pkg::DIR_RIGHT;
        if (s * s < 2 * ax * ax) return x > 0 ? jrde_pkg::DIR_RIGHT : jrde_pkg::DIR_LEFT;
        if (d > 0 && d * d > 2 * ax * ax) return y > 0 ? jrde_pkg::DIR_UP : jrde_pkg::DIR_DOWN;
        if (y > 0) return x > 0 ? jrde_pkg::DIR_UP_RIGHT : jrde_pkg::DIR_UP_LEFT;
        return x < 0 ? jrde_pkg::DIR_DOWN_LEFT : jrde_pkg::DIR_DOWN_RIGHT;
    endfunction

    function automatic void queue_event(t_stick_res e);
        if (evq.size() >= 16) void'(evq.pop_front());
        evq.push_back(e);
    endfunction

    function automatic t_stick_res condition_stick(logic req, logic [15:0] rx,
                                                   logic [15:0] ry);
        t_stick_res r, e;
        longint cx, cy, x, y, mag, dx, dy;
        bit was_c, is_c, was_e, is_e;
        r = '0;
        if (req == jrde_pkg::REQ_POLL) begin
            r.kind = 1'b1;
            if (evq.size() != 0) begin
                r = evq.pop_front();
                r.kind = 1'b1;
                r.ev_valid = 1'b1;
            end
            r.level = 5'(evq.size());
            return r;
        end
        cx = longint'(rx >> 1) - 16384;
        cy = longint'(ry >> 1) - 16384;
        x = 0; y = 0;
        if (cx * cx + cy * cy >= dz_q * dz_q) begin
            mag = isqrt(cx * cx + cy * cy);
            if (mag != 0) begin
                x = stretch(cx, mag, dz_q);
                y = stretch(cy, mag, dz_q);
            end
        end
        dx = x - last_x; dy = y - last_y;
        was_c = iabs(last_x) < dz_q && iabs(last_y) < dz_q;
        is_c = iabs(x) < dz_q && iabs(y) < dz_q;
        was_e = iabs(last_x) > 15564 || iabs(last_y) > 15564;
        is_e = iabs(x) > 15564 || iabs(y) > 15564;
        e = '0;
        e.px = 16'(x); e.py = 16'(y); e.dx = 17'(dx); e.dy = 17'(dy);
        if (dx * dx + dy * dy > thr_q * thr_q) begin
            e.ev_kind = jrde_pkg::EVT_MOVED; queue_event(e);
        end
        if (!was_c && is_c) begin
            e.ev_kind = jrde_pkg::EVT_CENTRED; queue_event(e);
        end
        if (!was_e && is_e) begin
            e.ev_kind = jrde_pkg::EVT_EDGE; queue_event(e);
        end
        last_x = x; last_y = y;
        r.px = 16'(x); r.py = 16'(y); r.dx = 17'(dx); r.dy = 17'(dy);
        r.cen = is_c; r.edge_f = is_e;
        r.dir = is_c ? jrde_pkg::DIR_CENTRE : sector(x, y);
        r.level = 5'(evq.size());
        return r;
    endfunction

    function automatic bit pick(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // valid stays up after a beat only until the next call drives or drops it
    task automatic send_req(logic req, logic [15:0] rx, logic [15:0] ry,
                            bit has_exp, t_stick_res exp_res);
        t_stick_res p;
        while (pick(send_idle)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        p = condition_stick(req, rx, ry);
        want_q.push_back(p);
        pinned_v.push_back(has_exp);
        pinned_q.push_back(exp_res);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_raw_x <= rx;
        i_raw_y <= ry;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        while (n < 80) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == jrde_pkg::CFG_DZ_RADIUS) dz_q = (val[13:0] > 8192) ? 8192 : val[13:0];
        else thr_q = val;
        @(posedge i_clk);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                t_stick_res got, w;
                got = '{o_resp_kind, o_pos_x, o_pos_y, o_move_dx, o_move_dy,
                        o_direction, o_is_centered, o_is_at_edge, o_event_valid,
                        o_event_kind, o_queue_level};
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    errors++;
                end else begin
                    w = want_q.pop_front();
                    if (pinned_v.pop_front()) begin
                        t_stick_res pin;
                        pin = pinned_q.pop_front();
                        if (pin != w) begin
                            $display("%0t: table row exp %h model %h", $time, pin, w);
                            errors++;
                        end
                    end else void'(pinned_q.pop_front());
                    if (got != w) begin
                        $display("%0t: exp %h got %h", $time, w, got);
                        errors++;
                    end
                end
            end
            i_out_stall <= pick(recv_stall);
        end
    end

    function automatic t_stick_res pin_res(logic k, longint x, longint y, longint dx,
                                           longint dy, logic [3:0] d, bit c,
                                           bit e, bit v, logic [1:0] ek, int lv);
        t_stick_res r;
        r = '{k, 16'(x), 16'(y), 17'(dx), 17'(dy), d, c, e, v, ek, 5'(lv)};
        return r;
    endfunction

    t_stick_row rows[$];

    task automatic fill_rows();
        rows.push_back('{jrde_pkg::REQ_POLL, 16'h0000, 16'h0000, 1'b1,
                         pin_res(1, 0, 0, 0, 0, jrde_pkg::DIR_CENTRE, 0, 0, 0,
                                 jrde_pkg::EVT_MOVED, 0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h8000, 16'h8000, 1'b1,
                         pin_res(0, 0, 0, 0, 0, jrde_pkg::DIR_CENTRE, 1, 0, 0,
                                 jrde_pkg::EVT_MOVED, 0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'hFFFF, 16'h8000, 1'b1,
                         pin_res(0, 16382, 0, 16382, 0, jrde_pkg::DIR_RIGHT, 0, 1, 0,
                                 jrde_pkg::EVT_MOVED, 2)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h0000, 16'h0000, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h8000, 16'hFFFF, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h8000, 16'h0000, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h0000, 16'h8000, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h8300, 16'h8000, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h8700, 16'h8300, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'hD000, 16'hB000, 1'b0, t_stick_res'(0)});
        rows.push_back('{jrde_pkg::REQ_SAMPLE, 16'h2000, 16'hE000, 1'b0, t_stick_res'(0)});
        for (int i = 0; i < 18; i++)
            rows.push_back('{jrde_pkg::REQ_POLL, 16'hAAAA, 16'h5555, 1'b0, t_stick_res'(0)});
    endtask

    task automatic random_burst(int n);
        logic [15:0] rx, ry;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5, 0))
                0: begin rx = $urandom; ry = $urandom; end
                1: begin
                    rx = 16'h8000 + $urandom_range(1200, 0) - 600;
                    ry = 16'h8000 + $urandom_range(1200, 0) - 600;
                end
                2: begin
                    rx = pick(50) ? 16'hFFFF - $urandom_range(3000, 0) : $urandom_range(3000, 0);
                    ry = $urandom;
                end
                3: begin rx = $urandom; ry = rx ^ $urandom_range(255, 0); end
                default: begin rx = $urandom; ry = 16'hFFFF - rx; end
            endcase
            send_req(pick(40) ? jrde_pkg::REQ_POLL : jrde_pkg::REQ_SAMPLE, rx, ry, 1'b0,
                     t_stick_res'(0));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fill_rows();
        foreach (rows[i])
            send_req(rows[i].req, rows[i].rx, rows[i].ry, rows[i].has_exp,
                     rows[i].exp_res);
        drain();
        write_reg(jrde_pkg::CFG_DZ_RADIUS, 15'd0);
        write_reg(jrde_pkg::CFG_MOVE_THR, 15'd0);
        send_req(jrde_pkg::REQ_SAMPLE, 16'h8000, 16'h8000, 1'b0, t_stick_res'(0));
        send_req(jrde_pkg::REQ_SAMPLE, 16'h8001, 16'h8000, 1'b0, t_stick_res'(0));
        random_burst(30);
        drain();
        write_reg(jrde_pkg::CFG_DZ_RADIUS, 15'h3FFF);
        write_reg(jrde_pkg::CFG_MOVE_THR, 15'h7FFF);
        random_burst(40);
        drain();
        write_reg(jrde_pkg::CFG_DZ_RADIUS, 15'd8192);
        write_reg(jrde_pkg::CFG_MOVE_THR, 15'd1000);
        random_burst(40);
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_reg(jrde_pkg::CFG_DZ_RADIUS, 15'($urandom_range(8192, 0)));
            write_reg(jrde_pkg::CFG_MOVE_THR,
                      pick(50) ? 15'($urandom_range(2000, 0)) : 15'($urandom));
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 71; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 71; end
                default: begin send_idle = 25; recv_stall = 25; end
            endcase
            random_burst(245);
        end
        drain();
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
sv/jrde_pkg.sv
sv/jrde_ram.sv
sv/joystick_radial_deadzone_events.sv
sv/jrde_checker.sv
tb/tb.sv
